FILE: rtl/sbl_pkg.sv
// Shared types and constants of the script byte lexer.
package sbl_pkg;

	localparam int unsigned MAX_SOURCE_BYTES = 65536;
	localparam int unsigned POS_LIMIT = (MAX_SOURCE_BYTES < 65536) ? MAX_SOURCE_BYTES : 65536;
	// A position or offset may reach one past the limit while it is being formed.
	localparam int unsigned PW = $clog2(POS_LIMIT + 2);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned MAX_TOKENS = 3;

	typedef enum logic [3:0] {
		K_IDENT  = 4'd0,
		K_NUMBER = 4'd1,
		K_STRING = 4'd2,
		K_OP     = 4'd3,
		K_LPAREN = 4'd4,
		K_RPAREN = 4'd5,
		K_LBRACE = 4'd6,
		K_RBRACE = 4'd7,
		K_COMMA  = 4'd8,
		K_EQ     = 4'd9,
		K_EQEQ   = 4'd10,
		K_LT     = 4'd11,
		K_GT     = 4'd12,
		K_END    = 4'd13,
		K_ERROR  = 4'd14
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// All tokens caused by one input byte, in emission order.
	typedef struct packed {
		logic [1:0]                 count;
		token_t [MAX_TOKENS-1:0]    tok;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: rtl/sbl_if.sv
// Handshake channels of the script byte lexer: source bytes in, tokens out.
interface sbl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       final_byte;

	modport source(output valid, output source_byte, output final_byte, input ready);
	modport sink(input valid, input source_byte, input final_byte, output ready);
endinterface

interface sbl_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        run_last;

	modport source(output valid, output token_kind, output token_start, output token_length,
		output run_last, input ready);
	modport sink(input valid, input token_kind, input token_start, input token_length,
		input run_last, output ready);
endinterface

FILE: rtl/sbl_front.sv
// Front end: lexer state machine that classifies each byte into a bundle of tokens.
module sbl_front (
	input  logic                clk,
	input  logic                arst_n,
	sbl_byte_if.sink            bytes,
	input  sbl_pkg::fifo_stat_t qstat,
	output logic                push,
	output sbl_pkg::bundle_t    bundle
);

	localparam int unsigned PW = sbl_pkg::PW;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_COMMENT = 3'd1,
		M_IDENT   = 3'd2,
		M_NUMBER  = 3'd3,
		M_STRING  = 3'd4,
		M_PENDEQ  = 3'd5,
		M_DISCARD = 3'd6
	} lex_mode_t;

	lex_mode_t         mode_q, mode_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [PW-1:0]     beg_q, beg_d;
	logic [PW-1:0]     p, endpos;
	logic [7:0]        c;
	logic              scan;
	logic              is_space, is_digit, is_alpha, is_word;
	logic              accept;

	function automatic logic [15:0] sat16(input logic [PW-1:0] v);
		if (32'(v) > 32'd65535) begin
			return 16'hFFFF;
		end
		return 16'(v);
	endfunction

	function automatic sbl_pkg::bundle_t add_token(input sbl_pkg::bundle_t b,
		input sbl_pkg::token_kind_t k, input logic [PW-1:0] s, input logic [PW-1:0] l);
		sbl_pkg::bundle_t r;
		r = b;
		r.tok[b.count] = '{kind: k, start: sat16(s), length: sat16(l)};
		r.count = b.count + 2'd1;
		return r;
	endfunction

	assign c        = bytes.source_byte;
	assign p        = pos_q;
	assign is_space = (c == 8'd32) || (c inside {[8'd9:8'd13]});
	assign is_digit = c inside {[8'h30:8'h39]};
	assign is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	assign is_word  = is_alpha || is_digit || (c == CH_UNDER);

	assign bytes.ready = !qstat.full;
	assign accept      = bytes.valid && bytes.ready;
	assign push        = accept && (bundle.count != 2'd0);

	always_comb begin
		bundle = '0;
		mode_d = mode_q;
		pos_d  = pos_q;
		beg_d  = beg_q;
		scan   = 1'b0;
		endpos = '0;

		if (32'(p) >= sbl_pkg::POS_LIMIT) begin
			// Past the position limit: drop any token in progress and flag once.
			if (mode_q != M_DISCARD) begin
				bundle = add_token(bundle, sbl_pkg::K_ERROR, p, PW'(1));
				mode_d = M_DISCARD;
			end
		end else begin
			pos_d = p + PW'(1);
			case (mode_q)
				M_IDENT: begin
					if (!is_word) begin
						bundle = add_token(bundle, sbl_pkg::K_IDENT, beg_q, p - beg_q);
						mode_d = M_IDLE;
						scan   = 1'b1;
					end
				end
				M_NUMBER: begin
					if (!(is_digit || c == CH_DOT)) begin
						bundle = add_token(bundle, sbl_pkg::K_NUMBER, beg_q, p - beg_q);
						mode_d = M_IDLE;
						scan   = 1'b1;
					end
				end
				M_PENDEQ: begin
					mode_d = M_IDLE;
					if (c == CH_EQ) begin
						bundle = add_token(bundle, sbl_pkg::K_EQEQ, beg_q, PW'(2));
					end else begin
						bundle = add_token(bundle, sbl_pkg::K_EQ, beg_q, PW'(1));
						scan   = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c == CH_NL) begin
						mode_d = M_IDLE;
					end
				end
				M_STRING: begin
					if (c == CH_QUOTE) begin
						bundle = add_token(bundle, sbl_pkg::K_STRING, beg_q, p - beg_q);
						mode_d = M_IDLE;
					end
				end
				M_IDLE: begin
					scan = 1'b1;
				end
				default: begin
				end
			endcase

			if (scan) begin
				if (is_space) begin
					mode_d = M_IDLE;
				end else if (c == CH_HASH) begin
					mode_d = M_COMMENT;
				end else if (is_alpha || c == CH_UNDER) begin
					mode_d = M_IDENT;
					beg_d  = p;
				end else if (is_digit) begin
					mode_d = M_NUMBER;
					beg_d  = p;
				end else if (c == CH_QUOTE) begin
					// String text starts after the opening quote.
					mode_d = M_STRING;
					beg_d  = p + PW'(1);
				end else if (c == CH_EQ) begin
					mode_d = M_PENDEQ;
					beg_d  = p;
				end else begin
					case (c)
						CH_LT:     bundle = add_token(bundle, sbl_pkg::K_LT, p, PW'(1));
						CH_GT:     bundle = add_token(bundle, sbl_pkg::K_GT, p, PW'(1));
						CH_LPAREN: bundle = add_token(bundle, sbl_pkg::K_LPAREN, p, PW'(1));
						CH_RPAREN: bundle = add_token(bundle, sbl_pkg::K_RPAREN, p, PW'(1));
						CH_LBRACE: bundle = add_token(bundle, sbl_pkg::K_LBRACE, p, PW'(1));
						CH_RBRACE: bundle = add_token(bundle, sbl_pkg::K_RBRACE, p, PW'(1));
						CH_COMMA:  bundle = add_token(bundle, sbl_pkg::K_COMMA, p, PW'(1));
						CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
							bundle = add_token(bundle, sbl_pkg::K_OP, p, PW'(1));
						default: begin
							bundle = add_token(bundle, sbl_pkg::K_ERROR, p, PW'(1));
							mode_d = M_DISCARD;
						end
					endcase
				end
			end
		end

		if (bytes.final_byte) begin
			endpos = (32'(p) + 32'd1 > sbl_pkg::POS_LIMIT) ? PW'(sbl_pkg::POS_LIMIT)
				: p + PW'(1);
			case (mode_d)
				M_IDENT:  bundle = add_token(bundle, sbl_pkg::K_IDENT, beg_d, endpos - beg_d);
				M_NUMBER: bundle = add_token(bundle, sbl_pkg::K_NUMBER, beg_d, endpos - beg_d);
				M_STRING: bundle = add_token(bundle, sbl_pkg::K_STRING, beg_d, endpos - beg_d);
				M_PENDEQ: bundle = add_token(bundle, sbl_pkg::K_EQ, beg_d, PW'(1));
				default: begin
				end
			endcase
			// After an error the source ends silently.
			if (mode_d != M_DISCARD) begin
				bundle = add_token(bundle, sbl_pkg::K_END, endpos, PW'(0));
			end
			mode_d = M_IDLE;
			pos_d  = '0;
			beg_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			beg_q  <= beg_d;
		end
	end

endmodule

FILE: rtl/sbl_queue.sv
// Short queue of token bundles between the front end and the back end.
module sbl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sbl_pkg::bundle_t    push_data,
	input  logic                pop,
	output sbl_pkg::bundle_t    head,
	output sbl_pkg::fifo_stat_t qstat
);

	localparam int unsigned QAW = sbl_pkg::QAW;

	sbl_pkg::bundle_t   mem_q [sbl_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QAW:0]       cnt_q;
	logic               do_push, do_pop;

	function automatic logic [QAW-1:0] next_ptr(input logic [QAW-1:0] ptr);
		if (ptr == QAW'(sbl_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + QAW'(1);
	endfunction

	assign qstat.full  = (cnt_q == (QAW+1)'(sbl_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/sbl_back.sv
// Back end: sends queued tokens one per cycle, unless stalled, through an output register.
module sbl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sbl_pkg::bundle_t    head,
	input  sbl_pkg::fifo_stat_t qstat,
	output logic                pop,
	sbl_token_if.source         tokens
);

	logic               valid_q;
	sbl_pkg::token_t    tok_q;
	logic               last_q;
	logic [1:0]         idx_q;
	logic               load, take, is_last;

	assign load    = !valid_q || tokens.ready;
	assign take    = load && !qstat.empty;
	assign is_last = (idx_q == head.count - 2'd1);
	assign pop     = take && is_last;

	assign tokens.valid        = valid_q;
	assign tokens.token_kind   = tok_q.kind;
	assign tokens.token_start  = tok_q.start;
	assign tokens.token_length = tok_q.length;
	assign tokens.run_last     = last_q;

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= head.tok[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !qstat.empty;
			if (take) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

FILE: rtl/script_byte_lexer.sv
// Top level of the script byte lexer: front end, bundle queue and token back end.
//
//  Channel   Dir   Payload                                        Handshake
//  bytes     in    source_byte[7:0], final_byte                   valid/ready
//  tokens    out   token_kind[3:0], token_start[15:0],            valid/ready
//                  token_length[15:0], run_last
//
// One byte is accepted per cycle while the bundle queue has room; the lexer state
// machine in the front end turns it into up to three tokens in that same cycle.
// Tokens leave one per cycle through the output register while the output is not stalled,
// passing through the queue memory first; a byte's tokens all leave before the next byte's.
// Reset clears the lexer state, the queue pointers and the output valid; no clearing pass.
// A stalled token output fills the four-entry queue before the byte input stalls.
module script_byte_lexer (
	input  logic        clk,
	input  logic        arst_n,
	sbl_byte_if.sink    bytes,
	sbl_token_if.source tokens
);

	sbl_pkg::bundle_t    bundle;
	sbl_pkg::bundle_t    head;
	sbl_pkg::fifo_stat_t qstat;
	logic                push;
	logic                pop;

	sbl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.qstat  (qstat),
		.push   (push),
		.bundle (bundle)
	);

	sbl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	sbl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

FILE: rtl/sbl_checker.sv
// Port-level checks of the script byte lexer and their binding to the top level.
module sbl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic        run_last
);

	// A token waiting on the output holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({token_kind, token_start, token_length, run_last}))
		else $error("token output changed while stalled");

	// End and error tokens always close the run of their byte.
	a_end_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == sbl_pkg::K_END || token_kind == sbl_pkg::K_ERROR)
			|-> run_last)
		else $error("end or error token not last of its byte");

	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == sbl_pkg::K_END |-> token_length == 16'd0)
		else $error("end token with nonzero length");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == sbl_pkg::K_ERROR |-> token_length == 16'd1)
		else $error("error token length is not one");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("token output valid during reset");

endmodule

bind script_byte_lexer sbl_checker u_sbl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (tokens.valid),
	.out_ready    (tokens.ready),
	.token_kind   (tokens.token_kind),
	.token_start  (tokens.token_start),
	.token_length (tokens.token_length),
	.run_last     (tokens.run_last)
);
